>>> sv/packet_flow_key_parser_core_macros.svh
// ----------------------------------------------------------------------------
// packet flow key parser assertion macros
// concurrent assertion wrappers shared by the parser rtl
// ----------------------------------------------------------------------------
`ifndef PACKET_FLOW_KEY_PARSER_CORE_MACROS_SVH
`define PACKET_FLOW_KEY_PARSER_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PFKP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pfkp assertion failed");

// property checked on every rising clock edge, reset included
`define PFKP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pfkp assertion failed");

`endif

>>> sv/pfkp_pkg.sv
// ----------------------------------------------------------------------------
// pfkp_pkg
// types and constants for the packet flow key parser
// ----------------------------------------------------------------------------
`default_nettype none

package pfkp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned DSCP_W   = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFF_W    = 7;

  localparam int unsigned MAX_VLAN_TAGS_DEF = 2;
  localparam int unsigned ETH_HDR_LEN       = 14;
  localparam int unsigned VLAN_TAG_LEN      = 4;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 16'd128;

  localparam logic [15:0] ETYPE_CTAG = 16'h8100;
  localparam logic [15:0] ETYPE_STAG = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_FRAG6 = 8'd44;

  localparam logic [LEN_W-1:0] IPV6_HDR_LEN = 16'd40;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_NOTIP   = 3'd2,
    ST_FRAG    = 3'd3,
    ST_OTHERL4 = 3'd4,
    ST_SHORT   = 3'd5,
    ST_BADIHL  = 3'd6
  } status_e;

endpackage

`default_nettype wire

>>> sv/pfkp_in_if.sv
// ----------------------------------------------------------------------------
// pfkp_in_if
// frame byte channel: one byte per beat with a last-byte mark
// ----------------------------------------------------------------------------
`default_nettype none

interface pfkp_in_if;
  import pfkp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> sv/pfkp_out_if.sv
// ----------------------------------------------------------------------------
// pfkp_out_if
// verdict channel: one beat per frame with status and flow key
// ----------------------------------------------------------------------------
`default_nettype none

interface pfkp_out_if;
  import pfkp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                is_ipv6;
  logic [BYTE_W-1:0]   l4_protocol;
  logic [DSCP_W-1:0]   dscp_value;
  logic [LEN_W-1:0]    ip_length;
  logic [PORT_W-1:0]   source_port;
  logic [PORT_W-1:0]   destination_port;
  logic [ADDR_W-1:0]   source_addr_high;
  logic [ADDR_W-1:0]   source_addr_low;
  logic [ADDR_W-1:0]   dest_addr_high;
  logic [ADDR_W-1:0]   dest_addr_low;

  modport source (
    output valid, output status, output is_ipv6, output l4_protocol,
    output dscp_value, output ip_length, output source_port,
    output destination_port, output source_addr_high, output source_addr_low,
    output dest_addr_high, output dest_addr_low, input ready
  );
  modport sink (
    input valid, input status, input is_ipv6, input l4_protocol,
    input dscp_value, input ip_length, input source_port,
    input destination_port, input source_addr_high, input source_addr_low,
    input dest_addr_high, input dest_addr_low, output ready
  );
endinterface

`default_nettype wire

>>> sv/packet_flow_key_parser_core.sv
// a last byte passes through the input stage register into the verdict register
// throughput: one frame byte per cycle unless stalled, set by the single parse stage
// the input stalls only when a last byte meets a verdict not yet taken
// reset: asynchronous active low; parser returns to the ethernet header,
// the output register empties and min_length returns to 128
// ----------------------------------------------------------------------------
// packet_flow_key_parser_core
// ethernet / vlan / ipv4-ipv6 / tcp-udp header parser giving one flow key
// verdict per frame
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_flow_key_parser_core_macros.svh"

module packet_flow_key_parser_core #(
  parameter int unsigned MAX_VLAN_TAGS = pfkp_pkg::MAX_VLAN_TAGS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pfkp_pkg::LEN_W-1:0] cfg_wdata_i,
  pfkp_in_if.sink                    in_i,
  pfkp_out_if.source                 out_o
);
  import pfkp_pkg::*;

  localparam int unsigned TagW = (MAX_VLAN_TAGS > 0) ? $clog2(MAX_VLAN_TAGS + 1) : 1;
  localparam int unsigned L3W  = $clog2(ETH_HDR_LEN + VLAN_TAG_LEN * MAX_VLAN_TAGS + 1);

  typedef enum logic [4:0] {
    PH_ETH  = 5'b00001,
    PH_IPV4 = 5'b00010,
    PH_IPV6 = 5'b00100,
    PH_L4   = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  // input stage
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              stall;
  logic              adv;
  logic              adv_last;

  // parser state
  logic [OFF_W-1:0]        off_q, off_d;
  phase_e                  phase_q, phase_d;
  logic [BYTE_W-1:0]       etype_hi_q, etype_hi_d;
  logic [TagW-1:0]         tags_q, tags_d;
  logic [L3W-1:0]          l3_q, l3_d;
  logic [OFF_W-1:0]        l4_q, l4_d;
  logic [3:0]              hw_q, hw_d;
  logic [0:15][BYTE_W-1:0] src_q, src_d;
  logic [0:15][BYTE_W-1:0] dst_q, dst_d;
  logic [PORT_W-1:0]       sport_q, sport_d;
  logic [PORT_W-1:0]       dport_q, dport_d;
  logic [BYTE_W-1:0]       proto_q, proto_d;
  logic [DSCP_W-1:0]       dscp_q, dscp_d;
  logic [LEN_W-1:0]        len_q, len_d;
  status_e                 verdict_q, verdict_d;
  logic                    is6_q, is6_d;
  logic                    frag_q, frag_d;
  logic [LEN_W-1:0]        min_len_q;

  // parse helpers
  logic [OFF_W-1:0] rel3;
  logic [OFF_W-1:0] rel4;
  logic [OFF_W-1:0] rel6_src;
  logic [OFF_W-1:0] rel6_dst;
  logic [OFF_W:0]   off_p1;
  logic [OFF_W:0]   off_p2;
  logic [15:0]      etype;
  logic             l4_ok_proto;
  status_e          res_status;
  logic             res_ok;

  // result register
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_is6_q;
  logic [BYTE_W-1:0] out_proto_q;
  logic [DSCP_W-1:0] out_dscp_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [PORT_W-1:0] out_sport_q;
  logic [PORT_W-1:0] out_dport_q;
  logic [ADDR_W-1:0] out_src_hi_q;
  logic [ADDR_W-1:0] out_src_lo_q;
  logic [ADDR_W-1:0] out_dst_hi_q;
  logic [ADDR_W-1:0] out_dst_lo_q;

  // a last byte waits while the previous verdict is still unread
  assign stall      = in_vld_q & in_last_q & out_valid_q & ~out_o.ready;
  assign adv        = in_vld_q & ~stall;
  assign adv_last   = adv & in_last_q;
  assign in_i.ready = ~stall;

  assign rel3     = off_q - OFF_W'(l3_q);
  assign rel4     = off_q - l4_q;
  assign rel6_src = rel3 - OFF_W'(8);
  assign rel6_dst = rel3 - OFF_W'(24);
  assign off_p1   = {1'b0, off_q} + (OFF_W+1)'(1);
  assign off_p2   = {1'b0, off_q} + (OFF_W+1)'(2);
  assign etype    = {etype_hi_q, in_byte_q};
  assign l4_ok_proto = (proto_q == PROTO_TCP) || (proto_q == PROTO_UDP);

  always_comb begin
    phase_d    = phase_q;
    etype_hi_d = etype_hi_q;
    tags_d     = tags_q;
    l3_d       = l3_q;
    l4_d       = l4_q;
    hw_d       = hw_q;
    src_d      = src_q;
    dst_d      = dst_q;
    sport_d    = sport_q;
    dport_d    = dport_q;
    proto_d    = proto_q;
    dscp_d     = dscp_q;
    len_d      = len_q;
    verdict_d  = verdict_q;
    is6_d      = is6_q;
    frag_d     = frag_q;
    off_d      = (&off_q) ? off_q : off_p1[OFF_W-1:0];

    case (phase_q)
      PH_ETH: begin
        if (off_p2 == (OFF_W+1)'(l3_q)) begin
          etype_hi_d = in_byte_q;
        end else if (off_p1 == (OFF_W+1)'(l3_q)) begin
          if (((etype == ETYPE_CTAG) || (etype == ETYPE_STAG)) &&
              (tags_q < TagW'(MAX_VLAN_TAGS))) begin
            tags_d = tags_q + TagW'(1);
            l3_d   = l3_q + L3W'(VLAN_TAG_LEN);
          end else if (etype == ETYPE_IPV4) begin
            phase_d = PH_IPV4;
          end else if (etype == ETYPE_IPV6) begin
            is6_d   = 1'b1;
            phase_d = PH_IPV6;
          end else begin
            verdict_d = ST_NOTIP;
            phase_d   = PH_DONE;
          end
        end
      end
      PH_IPV4: begin
        case (rel3)
          7'd0:    hw_d = in_byte_q[3:0];
          7'd1:    dscp_d = in_byte_q[7:2];
          7'd2:    len_d = {in_byte_q, 8'h00};
          7'd3:    len_d = {len_q[15:8], in_byte_q};
          7'd6:    if (in_byte_q[5:0] != 6'd0) frag_d = 1'b1;
          7'd7:    if (in_byte_q != 8'd0) frag_d = 1'b1;
          7'd9:    proto_d = in_byte_q;
          7'd12, 7'd13, 7'd14, 7'd15: src_d[{2'b00, rel3[1:0]}] = in_byte_q;
          7'd16, 7'd17, 7'd18, 7'd19: dst_d[{2'b00, rel3[1:0]}] = in_byte_q;
          default: ;
        endcase
        if (rel3 == 7'd19) begin
          phase_d = PH_DONE;
          if (frag_q) begin
            verdict_d = ST_FRAG;
          end else if (hw_q < 4'd5) begin
            verdict_d = ST_BADIHL;
          end else if (!l4_ok_proto) begin
            verdict_d = ST_OTHERL4;
          end else begin
            l4_d    = OFF_W'(l3_q) + OFF_W'({hw_q, 2'b00});
            phase_d = PH_L4;
          end
        end
      end
      PH_IPV6: begin
        case (rel3)
          7'd0:    dscp_d = {in_byte_q[3:0], 2'b00};
          7'd1:    dscp_d = {dscp_q[5:2], in_byte_q[7:6]};
          7'd4:    len_d = {in_byte_q, 8'h00};
          7'd5:    len_d = {len_q[15:8], in_byte_q} + IPV6_HDR_LEN;
          7'd6:    proto_d = in_byte_q;
          default: ;
        endcase
        if ((rel3 >= 7'd8) && (rel3 <= 7'd23)) begin
          src_d[rel6_src[3:0]] = in_byte_q;
        end
        if ((rel3 >= 7'd24) && (rel3 <= 7'd39)) begin
          dst_d[rel6_dst[3:0]] = in_byte_q;
        end
        if (rel3 == 7'd39) begin
          phase_d = PH_DONE;
          if (proto_q == PROTO_FRAG6) begin
            verdict_d = ST_FRAG;
          end else if (!l4_ok_proto) begin
            verdict_d = ST_OTHERL4;
          end else begin
            l4_d    = OFF_W'(l3_q) + OFF_W'(IPV6_HDR_LEN);
            phase_d = PH_L4;
          end
        end
      end
      PH_L4: begin
        case (rel4)
          7'd0:    sport_d = {in_byte_q, 8'h00};
          7'd1:    sport_d = {sport_q[15:8], in_byte_q};
          7'd2:    dport_d = {in_byte_q, 8'h00};
          7'd3:    dport_d = {dport_q[15:8], in_byte_q};
          default: ;
        endcase
        if (rel4 == ((proto_q == PROTO_TCP) ? 7'd19 : 7'd7)) begin
          verdict_d = (len_q < min_len_q) ? ST_SHORT : ST_OK;
          phase_d   = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  assign res_status = (phase_d == PH_DONE) ? verdict_d : ST_TRUNC;
  assign res_ok     = (res_status == ST_OK);

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LENGTH_RST;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // parser state, cleared after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      phase_q    <= PH_ETH;
      etype_hi_q <= '0;
      tags_q     <= '0;
      l3_q       <= L3W'(ETH_HDR_LEN);
      l4_q       <= '0;
      hw_q       <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      sport_q    <= '0;
      dport_q    <= '0;
      proto_q    <= '0;
      dscp_q     <= '0;
      len_q      <= '0;
      verdict_q  <= ST_OK;
      is6_q      <= 1'b0;
      frag_q     <= 1'b0;
    end else if (adv_last) begin
      off_q      <= '0;
      phase_q    <= PH_ETH;
      etype_hi_q <= '0;
      tags_q     <= '0;
      l3_q       <= L3W'(ETH_HDR_LEN);
      l4_q       <= '0;
      hw_q       <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      sport_q    <= '0;
      dport_q    <= '0;
      proto_q    <= '0;
      dscp_q     <= '0;
      len_q      <= '0;
      verdict_q  <= ST_OK;
      is6_q      <= 1'b0;
      frag_q     <= 1'b0;
    end else if (adv) begin
      off_q      <= off_d;
      phase_q    <= phase_d;
      etype_hi_q <= etype_hi_d;
      tags_q     <= tags_d;
      l3_q       <= l3_d;
      l4_q       <= l4_d;
      hw_q       <= hw_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      sport_q    <= sport_d;
      dport_q    <= dport_d;
      proto_q    <= proto_d;
      dscp_q     <= dscp_d;
      len_q      <= len_d;
      verdict_q  <= verdict_d;
      is6_q      <= is6_d;
      frag_q     <= frag_d;
    end
  end

  // verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // key fields are zero unless the frame is accepted
  always_ff @(posedge clk_i) begin
    if (adv_last) begin
      out_status_q <= res_status;
      out_is6_q    <= res_ok & is6_d;
      out_proto_q  <= res_ok ? proto_d : '0;
      out_dscp_q   <= res_ok ? dscp_d : '0;
      out_len_q    <= res_ok ? len_d : '0;
      out_sport_q  <= res_ok ? sport_d : '0;
      out_dport_q  <= res_ok ? dport_d : '0;
      out_src_hi_q <= res_ok ? src_d[0:7] : '0;
      out_src_lo_q <= res_ok ? src_d[8:15] : '0;
      out_dst_hi_q <= res_ok ? dst_d[0:7] : '0;
      out_dst_lo_q <= res_ok ? dst_d[8:15] : '0;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.is_ipv6          = out_is6_q;
  assign out_o.l4_protocol      = out_proto_q;
  assign out_o.dscp_value       = out_dscp_q;
  assign out_o.ip_length        = out_len_q;
  assign out_o.source_port      = out_sport_q;
  assign out_o.destination_port = out_dport_q;
  assign out_o.source_addr_high = out_src_hi_q;
  assign out_o.source_addr_low  = out_src_lo_q;
  assign out_o.dest_addr_high   = out_dst_hi_q;
  assign out_o.dest_addr_low    = out_dst_lo_q;

  `PFKP_ASSERT(a_no_verdict_overwrite, clk_i, rst_ni, (out_valid_q && !out_o.ready) |-> !adv_last)
  `PFKP_ASSERT(a_last_gives_verdict, clk_i, rst_ni, adv_last |=> out_valid_q)
  `PFKP_ASSERT(a_frame_restart, clk_i, rst_ni,
    adv_last |=> (phase_q == PH_ETH) && (off_q == '0) && (tags_q == '0))
  `PFKP_ASSERT(a_reject_clears_key, clk_i, rst_ni,
    (out_valid_q && (out_status_q != ST_OK)) |->
      (out_sport_q == '0) && (out_dport_q == '0) && (out_src_hi_q == '0) &&
      (out_dst_hi_q == '0) && (out_len_q == '0))
  `PFKP_ASSERT_ALWAYS(a_tag_limit, clk_i, tags_q <= TagW'(MAX_VLAN_TAGS))

endmodule

`default_nettype wire

>>> sim/packet_flow_key_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_flow_key_parser_core_tb
// self-checking bench for the flow key parser: frames are sent one byte per
// beat, a cycle-free predictor works out each verdict and flow key, and every
// verdict beat is compared field by field under varied idle and stall phases
// ----------------------------------------------------------------------------

module packet_flow_key_parser_core_tb;
  import pfkp_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 6;
  localparam int TAG_LIMIT    = MAX_VLAN_TAGS_DEF;

  typedef enum logic [2:0] {AT_ETH, AT_IPV4, AT_IPV6, AT_L4, AT_DONE} hdr_phase_e;

  typedef struct packed {
    status_e           status;
    logic              is_ipv6;
    logic [7:0]        l4_protocol;
    logic [5:0]        dscp_value;
    logic [15:0]       ip_length;
    logic [15:0]       source_port;
    logic [15:0]       destination_port;
    logic [63:0]       source_addr_high;
    logic [63:0]       source_addr_low;
    logic [63:0]       dest_addr_high;
    logic [63:0]       dest_addr_low;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  pfkp_in_if  in_bus ();
  pfkp_out_if out_bus ();

  packet_flow_key_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser state mirror
  logic [15:0] min_len_q;
  logic [6:0]  byte_pos;
  hdr_phase_e  hdr_phase;
  logic [15:0] etype_q;
  int          tag_cnt;
  int          l3_base;
  int          l4_base;
  logic [3:0]  ihl_q;
  logic [63:0] src_key [2];
  logic [63:0] dst_key [2];
  logic [15:0] l4_port [2];
  logic [7:0]  proto_q;
  logic [5:0]  dscp_q;
  logic [15:0] len_q;
  status_e     parse_status;
  logic        v6_q;
  logic        frag_q;

  verdict_t    expected_verdicts[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;

  logic [7:0]  frame_bytes[$];
  int          etype_at;
  int          addr_at;
  int          l4_at;

  function automatic void clear_frame_state();
    byte_pos     = '0;
    hdr_phase    = AT_ETH;
    etype_q      = '0;
    tag_cnt      = 0;
    l3_base      = ETH_HDR_LEN;
    l4_base      = 0;
    ihl_q        = '0;
    src_key[0]   = '0;
    src_key[1]   = '0;
    dst_key[0]   = '0;
    dst_key[1]   = '0;
    l4_port[0]   = '0;
    l4_port[1]   = '0;
    proto_q      = '0;
    dscp_q       = '0;
    len_q        = '0;
    parse_status = ST_OK;
    v6_q         = 1'b0;
    frag_q       = 1'b0;
  endfunction

  function automatic void store_addr(input logic dst, input int k, input logic [7:0] b);
    logic [63:0] w;
    w = {56'd0, b} << (56 - 8 * (k % 8));
    if (dst) begin
      dst_key[k / 8] = dst_key[k / 8] | w;
    end else begin
      src_key[k / 8] = src_key[k / 8] | w;
    end
  endfunction

  function automatic void conclude(input status_e s);
    parse_status = s;
    hdr_phase    = AT_DONE;
  endfunction

  function automatic void start_l4(input int at);
    if (proto_q != PROTO_TCP && proto_q != PROTO_UDP) begin
      conclude(ST_OTHERL4);
    end else begin
      l4_base   = at % 128;
      hdr_phase = AT_L4;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    int       off;
    int       rel;
    status_e  s;
    verdict_t v;
    off = byte_pos;
    case (hdr_phase)
      AT_ETH: begin
        if (off + 2 == l3_base) begin
          etype_q = {b, 8'h00};
        end else if (off + 1 == l3_base) begin
          etype_q[7:0] = b;
          if ((etype_q == ETYPE_CTAG || etype_q == ETYPE_STAG) && tag_cnt < TAG_LIMIT) begin
            tag_cnt++;
            l3_base += VLAN_TAG_LEN;
          end else if (etype_q == ETYPE_IPV4) begin
            hdr_phase = AT_IPV4;
          end else if (etype_q == ETYPE_IPV6) begin
            v6_q      = 1'b1;
            hdr_phase = AT_IPV6;
          end else begin
            conclude(ST_NOTIP);
          end
        end
      end
      AT_IPV4: begin
        rel = off - l3_base;
        if (rel == 0) ihl_q = b[3:0];
        else if (rel == 1) dscp_q = b[7:2];
        else if (rel == 2) len_q = {b, 8'h00};
        else if (rel == 3) len_q[7:0] = b;
        else if (rel == 6) begin
          if (b[5:0] != 0) frag_q = 1'b1;
        end else if (rel == 7) begin
          if (b != 0) frag_q = 1'b1;
        end else if (rel == 9) proto_q = b;
        else if (rel >= 12 && rel <= 15) store_addr(1'b0, rel - 12, b);
        else if (rel >= 16 && rel <= 19) store_addr(1'b1, rel - 16, b);
        if (rel == 19) begin
          if (frag_q) conclude(ST_FRAG);
          else if (ihl_q < 5) conclude(ST_BADIHL);
          else start_l4(l3_base + 4 * ihl_q);
        end
      end
      AT_IPV6: begin
        rel = off - l3_base;
        if (rel == 0) dscp_q = {b[3:0], 2'b00};
        else if (rel == 1) dscp_q[1:0] = b[7:6];
        else if (rel == 4) len_q = {b, 8'h00};
        else if (rel == 5) len_q = {len_q[15:8], b} + IPV6_HDR_LEN;
        else if (rel == 6) proto_q = b;
        else if (rel >= 8 && rel <= 23) store_addr(1'b0, rel - 8, b);
        else if (rel >= 24 && rel <= 39) store_addr(1'b1, rel - 24, b);
        if (rel == 39) begin
          if (proto_q == PROTO_FRAG6) conclude(ST_FRAG);
          else start_l4(l3_base + 40);
        end
      end
      AT_L4: begin
        rel = off - l4_base;
        if (rel == 0) l4_port[0] = {b, 8'h00};
        else if (rel == 1) l4_port[0][7:0] = b;
        else if (rel == 2) l4_port[1] = {b, 8'h00};
        else if (rel == 3) l4_port[1][7:0] = b;
        if (rel == ((proto_q == PROTO_TCP) ? 19 : 7)) begin
          conclude((len_q < min_len_q) ? ST_SHORT : ST_OK);
        end
      end
      default: begin
      end
    endcase
    if (byte_pos < 7'd127) byte_pos++;
    if (last) begin
      v = '0;
      s = (hdr_phase == AT_DONE) ? parse_status : ST_TRUNC;
      v.status = s;
      if (s == ST_OK) begin
        v.is_ipv6          = v6_q;
        v.l4_protocol      = proto_q;
        v.dscp_value       = dscp_q;
        v.ip_length        = len_q;
        v.source_port      = l4_port[0];
        v.destination_port = l4_port[1];
        v.source_addr_high = src_key[0];
        v.source_addr_low  = src_key[1];
        v.dest_addr_high   = dst_key[0];
        v.dest_addr_low    = dst_key[1];
      end
      expected_verdicts.push_back(v);
      clear_frame_state();
    end
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_verdicts.size() == 0) begin
        $error("verdict beat with status %0d while none is expected", out_bus.status);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        compare_field("status", want.status, out_bus.status);
        compare_field("is_ipv6", want.is_ipv6, out_bus.is_ipv6);
        compare_field("l4_protocol", want.l4_protocol, out_bus.l4_protocol);
        compare_field("dscp_value", want.dscp_value, out_bus.dscp_value);
        compare_field("ip_length", want.ip_length, out_bus.ip_length);
        compare_field("source_port", want.source_port, out_bus.source_port);
        compare_field("destination_port", want.destination_port, out_bus.destination_port);
        compare_field("source_addr_high", want.source_addr_high, out_bus.source_addr_high);
        compare_field("source_addr_low", want.source_addr_low, out_bus.source_addr_low);
        compare_field("dest_addr_high", want.dest_addr_high, out_bus.dest_addr_high);
        compare_field("dest_addr_low", want.dest_addr_low, out_bus.dest_addr_low);
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    predict_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic drain_verdicts();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_length(input logic [15:0] value);
    drain_verdicts();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_len_q    = value;
  endtask

  function automatic logic [7:0] any_byte();
    return $urandom_range(255);
  endfunction

  function automatic void build_frame(input int tags, input logic v6, input logic [7:0] proto,
                                      input logic [15:0] iplen, input logic [3:0] ihl,
                                      input logic [15:0] frag, input int pad);
    logic [15:0] tpid;
    logic [15:0] ety;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(any_byte());
    repeat (tags) begin
      tpid = $urandom_range(1) ? ETYPE_CTAG : ETYPE_STAG;
      frame_bytes.push_back(tpid[15:8]);
      frame_bytes.push_back(tpid[7:0]);
      frame_bytes.push_back(any_byte());
      frame_bytes.push_back(any_byte());
    end
    etype_at = frame_bytes.size();
    ety = v6 ? ETYPE_IPV6 : ETYPE_IPV4;
    frame_bytes.push_back(ety[15:8]);
    frame_bytes.push_back(ety[7:0]);
    if (v6) begin
      frame_bytes.push_back({4'h6, any_byte() & 8'h0F});
      repeat (3) frame_bytes.push_back(any_byte());
      frame_bytes.push_back(iplen[15:8]);
      frame_bytes.push_back(iplen[7:0]);
      frame_bytes.push_back(proto);
      frame_bytes.push_back(any_byte());
      addr_at = frame_bytes.size();
      repeat (32) frame_bytes.push_back(any_byte());
    end else begin
      frame_bytes.push_back({4'h4, ihl});
      frame_bytes.push_back(any_byte());
      frame_bytes.push_back(iplen[15:8]);
      frame_bytes.push_back(iplen[7:0]);
      repeat (2) frame_bytes.push_back(any_byte());
      frame_bytes.push_back(frag[15:8]);
      frame_bytes.push_back(frag[7:0]);
      frame_bytes.push_back(any_byte());
      frame_bytes.push_back(proto);
      repeat (2) frame_bytes.push_back(any_byte());
      addr_at = frame_bytes.size();
      repeat (8) frame_bytes.push_back(any_byte());
      if (ihl > 5) repeat ((ihl - 5) * 4) frame_bytes.push_back(any_byte());
    end
    l4_at = frame_bytes.size();
    repeat ((proto == PROTO_TCP) ? 20 : 8) frame_bytes.push_back(any_byte());
    repeat (pad) frame_bytes.push_back(any_byte());
  endfunction

  function automatic void fill_bytes(input int from, input int count, input logic [7:0] value);
    for (int i = 0; i < count; i++) frame_bytes[from + i] = value;
  endfunction

  function automatic void cut_frame(input int keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endfunction

  function automatic void set_ethertype(input logic [15:0] value);
    frame_bytes[etype_at]     = value[15:8];
    frame_bytes[etype_at + 1] = value[7:0];
  endfunction

  function automatic void build_random_frame();
    int          kind;
    int          r;
    int          tags;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    logic [15:0] frag;
    logic [15:0] iplen;
    kind = $urandom_range(99);
    if (kind < 6) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(any_byte());
      return;
    end
    r = $urandom_range(99);
    tags = (r < 60) ? 0 : (r < 80) ? 1 : (r < 93) ? 2 : 3;
    r = $urandom_range(99);
    proto = (r < 45) ? PROTO_TCP : (r < 85) ? PROTO_UDP : (r < 90) ? PROTO_FRAG6 : any_byte();
    r = $urandom_range(99);
    ihl = (r < 80) ? 4'd5 : (r < 92) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
    r = $urandom_range(99);
    frag = (r < 80) ? 16'h0000 : (r < 88) ? 16'h4000 : 16'($urandom_range(65535));
    iplen = $urandom_range(1) ? 16'($urandom_range(0, 400)) : 16'($urandom_range(65535));
    build_frame(tags, $urandom_range(1), proto, iplen, ihl, frag, $urandom_range(0, 6));
    if (kind < 14) begin
      set_ethertype($urandom_range(65535));
    end else if (kind < 28) begin
      cut_frame($urandom_range(1, frame_bytes.size()));
    end
  endfunction

  task automatic test_accepted_frames();
    build_frame(0, 1'b0, PROTO_TCP, 16'hFFFF, 4'd5, 16'h0000, 0);
    frame_bytes[etype_at + 3] = 8'hFF;
    fill_bytes(addr_at, 8, 8'hFF);
    fill_bytes(l4_at, 4, 8'hFF);
    send_frame();
    build_frame(0, 1'b0, PROTO_UDP, 16'd128, 4'd15, 16'h4000, 3);
    frame_bytes[etype_at + 3] = 8'h00;
    fill_bytes(addr_at, 8, 8'h00);
    fill_bytes(l4_at, 4, 8'h00);
    send_frame();
    build_frame(2, 1'b1, PROTO_TCP, 16'hFFF0, 4'd5, 16'h0000, 0);
    frame_bytes[etype_at + 2] = 8'h6F;
    frame_bytes[etype_at + 3] = 8'hFF;
    fill_bytes(addr_at, 32, 8'hFF);
    fill_bytes(l4_at, 4, 8'hFF);
    send_frame();
    build_frame(1, 1'b1, PROTO_UDP, 16'd88, 4'd5, 16'h0000, 2);
    fill_bytes(addr_at, 32, 8'h00);
    send_frame();
    build_frame(0, 1'b0, PROTO_UDP, 16'd600, 4'd5, 16'h0000, 150);
    send_frame();
  endtask

  task automatic test_truncated_frames();
    frame_bytes.delete();
    frame_bytes.push_back(any_byte());
    send_frame();
    build_frame(0, 1'b0, PROTO_TCP, 16'd300, 4'd5, 16'h0000, 0);
    cut_frame(13);
    send_frame();
    build_frame(1, 1'b0, PROTO_TCP, 16'd300, 4'd6, 16'h0000, 0);
    cut_frame(l4_at + 19);
    send_frame();
    build_frame(0, 1'b1, PROTO_UDP, 16'd300, 4'd5, 16'h0000, 0);
    cut_frame(etype_at + 41);
    send_frame();
  endtask

  task automatic test_rejected_frames();
    build_frame(0, 1'b0, PROTO_TCP, 16'd300, 4'd5, 16'h0000, 0);
    set_ethertype(16'h0806);
    send_frame();
    build_frame(3, 1'b0, PROTO_TCP, 16'd300, 4'd5, 16'h0000, 0);
    send_frame();
    build_frame(0, 1'b0, PROTO_TCP, 16'd300, 4'd5, 16'h2000, 0);
    send_frame();
    build_frame(2, 1'b0, PROTO_UDP, 16'd300, 4'd5, 16'h0001, 0);
    send_frame();
    build_frame(0, 1'b0, PROTO_TCP, 16'd300, 4'd4, 16'h0000, 0);
    send_frame();
    build_frame(0, 1'b0, PROTO_TCP, 16'd300, 4'd0, 16'h2000, 0);
    send_frame();
    build_frame(0, 1'b0, 8'd1, 16'd300, 4'd3, 16'h0000, 0);
    send_frame();
    build_frame(1, 1'b0, 8'd1, 16'd300, 4'd5, 16'h0000, 0);
    send_frame();
    build_frame(0, 1'b1, PROTO_FRAG6, 16'd300, 4'd5, 16'h0000, 0);
    send_frame();
    build_frame(0, 1'b1, 8'd0, 16'd300, 4'd5, 16'h0000, 4);
    send_frame();
  endtask

  task automatic test_length_threshold();
    build_frame(0, 1'b0, PROTO_TCP, 16'd20, 4'd5, 16'h0000, 0);
    send_frame();
    write_min_length(16'd0);
    build_frame(0, 1'b0, PROTO_TCP, 16'd0, 4'd5, 16'h0000, 0);
    send_frame();
    write_min_length(16'hFFFF);
    build_frame(0, 1'b0, PROTO_UDP, 16'hFFFE, 4'd5, 16'h0000, 0);
    send_frame();
    build_frame(0, 1'b1, PROTO_UDP, 16'hFFD7, 4'd5, 16'h0000, 0);
    send_frame();
    write_min_length(16'd129);
    build_frame(0, 1'b0, PROTO_TCP, 16'd128, 4'd5, 16'h0000, 0);
    send_frame();
    write_min_length(MIN_LENGTH_RST);
  endtask

  task automatic test_random_traffic();
    int send_pct [4] = '{0, 86, 0, 14};
    int recv_pct [4] = '{0, 0, 86, 14};
    int phase_bytes;
    int frames;
    for (int p = 0; p < 4; p++) begin
      write_min_length((p == 3) ? 16'($urandom_range(65535)) : 16'($urandom_range(0, 300)));
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      phase_bytes = 0;
      frames = 0;
      while (phase_bytes < 225 || frames < 20) begin
        build_random_frame();
        phase_bytes += frame_bytes.size();
        send_frame();
        frames++;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.last_byte  = 1'b0;
    out_bus.ready     = 1'b0;
    min_len_q         = MIN_LENGTH_RST;
    clear_frame_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_accepted_frames();
    test_truncated_frames();
    test_rejected_frames();
    test_length_threshold();
    test_random_traffic();

    drain_verdicts();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
